// ===== hdl/multi_queue_manager_assert.svh =====
// Assertion macros shared by the checker files of the queue manager.
// No dependencies; included by bare file name.
`ifndef MULTI_QUEUE_MANAGER_ASSERT_SVH
`define MULTI_QUEUE_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MQM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("queue manager check failed");

// Next-cycle implication, disabled during reset.
`define MQM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("queue manager check failed");

`endif

// ===== hdl/mqm_pkg.sv =====
// Shared constants and types for the multi-queue manager.
// No dependencies.
package mqm_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 128;

    localparam int QNUM_W  = 4;
    localparam int VALUE_W = 32;

    // Input tdata: queue_number, value, zero pad to whole bytes
    localparam int S_TDATA_W = ((QNUM_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = VALUE_W;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

endpackage

// ===== hdl/mqm_ptr_table.sv =====
// Per-queue head/tail/empty table in a memory with a registered read.
// Valid bits per queue make unwritten entries read as the empty state.
module mqm_ptr_table #(
    parameter int NUM_QUEUES = 8,
    parameter int PTR_W      = 7,
    parameter int QIDX_W     = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [QIDX_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [QIDX_W-1:0] i_wr_addr,
    input  logic [PTR_W-1:0]  i_wr_head,
    input  logic [PTR_W-1:0]  i_wr_tail,
    input  logic              i_wr_empty,
    output logic [PTR_W-1:0]  o_rd_head,
    output logic [PTR_W-1:0]  o_rd_tail,
    output logic              o_rd_empty
);

    localparam int REC_W = 2 * PTR_W + 1;

    // record: {head, tail, empty}
    logic [REC_W-1:0]      r_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_vld;
    logic [REC_W-1:0]      r_rd_q;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_head, i_wr_tail, i_wr_empty};
        end
        if (i_rd_en) begin
            r_rd_q   <= r_mem[i_rd_addr];
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // never-written queue reads as empty with head and tail at zero
    assign o_rd_head  = r_rd_vld ? r_rd_q[REC_W-1 -: PTR_W] : '0;
    assign o_rd_tail  = r_rd_vld ? r_rd_q[PTR_W:1] : '0;
    assign o_rd_empty = r_rd_vld ? r_rd_q[0] : 1'b1;

endmodule

// ===== hdl/multi_queue_manager.sv =====
// Multi-queue manager top level: request FSM and shared entry store.
// Depends on mqm_pkg and mqm_ptr_table.

// NUM_QUEUES linear FIFO queues of QUEUE_DEPTH words share one entry store.
// One request is handled at a time: an enqueue or a rejected request goes
// from acceptance through the pointer table read (S_PTR) back to idle, and a
// successful dequeue also passes through the entry store read (S_DATA).
// Both memories have a registered read; a stalled output holds the FSM in
// S_PTR or S_DATA. The result register lets a new request be accepted while
// the previous result still waits. No clearing pass is needed after reset:
// per-queue valid bits mark the pointer table empty at once.
module multi_queue_manager
    import mqm_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [3:0] queue_number, [35:4] value
    input  logic                 i_s_axis_tuser,  // [0] req_type
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] data_out
    output logic [1:0]           o_m_axis_tuser   // [1:0] status
);

    localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PTR,
        S_DATA
    } t_state;

    t_state              r_state;
    logic                r_req;
    logic                r_invalid;
    logic [QIDX_W-1:0]   r_qidx;
    logic [STORE_AW-1:0] r_base;
    logic [VALUE_W-1:0]  r_value;
    logic                r_m_valid;
    t_status             r_m_status;
    logic [VALUE_W-1:0]  r_m_data;

    logic [VALUE_W-1:0]  r_store [STORE_DEPTH];
    logic [VALUE_W-1:0]  r_store_q;

    logic [QNUM_W-1:0]   w_qnum;
    logic [QNUM_W-1:0]   w_qsub;
    logic [QIDX_W-1:0]   w_qidx;
    logic                w_accept;
    logic                w_out_free;
    logic                w_res_load;
    logic [PTR_W-1:0]    w_head;
    logic [PTR_W-1:0]    w_tail;
    logic                w_empty;

    logic                w_ptr_wr;
    logic [PTR_W-1:0]    w_new_head;
    logic [PTR_W-1:0]    w_new_tail;
    logic                w_new_empty;
    logic                w_st_wr;
    logic                w_st_rd;
    logic [STORE_AW-1:0] w_st_addr;
    logic                w_to_data;
    t_status             w_status;

    assign w_qnum          = i_s_axis_tdata[QNUM_W-1:0];
    assign w_qsub          = w_qnum - QNUM_W'(1);
    assign w_qidx          = w_qsub[QIDX_W-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign w_res_load      = w_out_free &&
                             ((r_state == S_PTR && !w_to_data) || (r_state == S_DATA));

    mqm_ptr_table #(
        .NUM_QUEUES (NUM_QUEUES),
        .PTR_W      (PTR_W),
        .QIDX_W     (QIDX_W)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_qidx),
        .i_wr_en    (w_ptr_wr),
        .i_wr_addr  (r_qidx),
        .i_wr_head  (w_new_head),
        .i_wr_tail  (w_new_tail),
        .i_wr_empty (w_new_empty),
        .o_rd_head  (w_head),
        .o_rd_tail  (w_tail),
        .o_rd_empty (w_empty)
    );

    // pointer update and store access, decided in the pointer-read cycle
    always_comb begin
        w_ptr_wr    = 1'b0;
        w_new_head  = w_head;
        w_new_tail  = w_tail;
        w_new_empty = w_empty;
        w_st_wr     = 1'b0;
        w_st_rd     = 1'b0;
        w_st_addr   = r_base;
        w_to_data   = 1'b0;
        w_status    = ST_OK;
        if (r_invalid) begin
            w_status = ST_INVALID;
        end else if (r_req == REQ_ENQ) begin
            if (w_empty) begin
                w_new_head  = '0;
                w_new_tail  = '0;
                w_new_empty = 1'b0;
                w_ptr_wr    = 1'b1;
                w_st_wr     = 1'b1;
            end else if (w_tail >= PTR_W'(QUEUE_DEPTH - 1)) begin
                w_status = ST_OVERFLOW;
            end else begin
                w_new_tail = w_tail + PTR_W'(1);
                w_ptr_wr   = 1'b1;
                w_st_wr    = 1'b1;
                w_st_addr  = r_base + STORE_AW'(w_new_tail);
            end
        end else begin
            if (w_empty || (w_head > w_tail)) begin
                w_status = ST_UNDERFLOW;
            end else begin
                w_st_rd   = 1'b1;
                w_st_addr = r_base + STORE_AW'(w_head);
                w_ptr_wr  = 1'b1;
                w_to_data = 1'b1;
                if (w_head == w_tail) begin
                    // drain: back to the empty state
                    w_new_head  = '0;
                    w_new_tail  = '0;
                    w_new_empty = 1'b1;
                end else begin
                    w_new_head = w_head + PTR_W'(1);
                end
            end
        end
        // nothing commits until the result can be placed
        if (!(r_state == S_PTR && w_out_free)) begin
            w_ptr_wr = 1'b0;
            w_st_wr  = 1'b0;
            w_st_rd  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_wr) begin
            r_store[w_st_addr] <= r_value;
        end
        if (w_st_rd) begin
            r_store_q <= r_store[w_st_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_PTR;
                    end
                end
                S_PTR: begin
                    if (w_out_free) begin
                        if (w_to_data) begin
                            r_state <= S_DATA;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // request and result payload
        if (w_accept) begin
            r_req     <= i_s_axis_tuser;
            r_invalid <= (w_qnum == '0) || (w_qnum > QNUM_W'(NUM_QUEUES));
            r_qidx    <= w_qidx;
            r_base    <= STORE_AW'(w_qidx) * STORE_AW'(QUEUE_DEPTH);
            r_value   <= i_s_axis_tdata[QNUM_W +: VALUE_W];
        end
        if (r_state == S_PTR && w_out_free && !w_to_data) begin
            r_m_status <= w_status;
            r_m_data   <= '0;
        end else if (r_state == S_DATA && w_out_free) begin
            r_m_status <= ST_OK;
            r_m_data   <= r_store_q;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_status;

endmodule

// ===== hdl/mqm_checker.sv =====
// Port-level checks for the multi-queue manager, bound to the top level.
// Depends on multi_queue_manager_assert.svh.
`include "multi_queue_manager_assert.svh"

module mqm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] i_m_axis_tdata,
    input logic [1:0]  i_m_axis_tuser
);

    // a stalled result holds
    `MQM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))

    // one request in flight: no acceptance right after a transaction
    `MQM_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && i_s_axis_tready, !i_s_axis_tready)

    // reset leaves no result pending
    `MQM_ASSERT_NOW(a_reset_clears, i_clk, i_rst_n, $past(!i_rst_n), !i_m_axis_tvalid)

endmodule

bind multi_queue_manager mqm_checker u_mqm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);
